// ===== src/scfl_pkg.sv =====
// shared types, constants and helper functions for the size-class free-list allocator
`timescale 1ns / 1ps
`default_nettype none
package scfl_pkg;

  localparam int unsigned DEF_ARENA_BYTES = 65536;
  localparam int unsigned CHUNK_BYTES     = 4096;
  localparam int unsigned NUM_CLASSES     = 8;
  localparam int unsigned SLOT_SHIFT      = 5;
  localparam int unsigned HDR_BYTES       = 8;
  localparam int unsigned MIN_BLOCK       = 32;
  localparam int unsigned MAX_SMALL       = CHUNK_BYTES - HDR_BYTES;
  localparam int unsigned REM_W           = 13;
  localparam int unsigned CLS_W           = 3;
  localparam int unsigned FO_W            = 12;

  localparam logic [FO_W-1:0] FO_RESET = 12'd128;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic REG_FIRST_OFFSET = 1'b0;

  localparam logic [3:0] CLS_BULK = 4'd8;

  localparam logic [2:0] STAT_LIST      = 3'd0;
  localparam logic [2:0] STAT_HEAP      = 3'd1;
  localparam logic [2:0] STAT_BULK      = 3'd2;
  localparam logic [2:0] STAT_ZERO      = 3'd3;
  localparam logic [2:0] STAT_OOM       = 3'd4;
  localparam logic [2:0] STAT_FREED     = 3'd5;
  localparam logic [2:0] STAT_BULK_FREE = 3'd6;
  localparam logic [2:0] STAT_NULL_FREE = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FREE_RD,
    ST_SETUP,
    ST_SIZE,
    ST_CLASS,
    ST_POP_RD,
    ST_NEXT,
    ST_OOM,
    ST_RETIRE,
    ST_HEAP_HDR,
    ST_HEAP_REM
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic cls_we;
  } mem_ctl_t;

  typedef struct packed {
    logic        req_type;
    logic [19:0] req_size;
    logic [31:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] user_addr;
    logic [3:0]  size_class;
    logic [2:0]  status;
  } out_item_t;

  // smallest class whose block holds v + 1 bytes, v = size + header - 1
  function automatic logic [CLS_W-1:0] class_of(input logic [11:0] v);
    logic [CLS_W-1:0] c;
    c = '0;
    for (int i = 0; i < 7; i++) begin
      if (v[i+5]) c = CLS_W'(i + 1);
    end
    return c;
  endfunction

  // largest class that fits in a chunk remainder
  function automatic logic [CLS_W-1:0] rem_class(input logic [11:0] r);
    logic [CLS_W-1:0] c;
    c = '0;
    for (int i = 0; i < 7; i++) begin
      if (r[i+5]) c = CLS_W'(i);
    end
    return c;
  endfunction

  function automatic out_item_t mk_out(input logic [15:0] a, input logic [3:0] c,
                                       input logic [2:0] s);
    out_item_t o;
    o.user_addr  = a;
    o.size_class = c;
    o.status     = s;
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== src/size_class_free_list_allocator.sv =====
// top level: request sequencer, list heads, chunk pointer and config register
// each item steps through the sequencer states up to its result strobe;
// rejected free and zero size end in decode, a free reads the header class and then pushes it,
// an alloc sizes, classes and then pops a list, cuts the heap or reports out of memory,
// a chunk change adds the next-chunk and limit checks and may retire the remainder first,
// the first alloc adds chunk setup; one item at a time, the next is taken in the strobe cycle
// results cannot be stalled; reset clears list heads, chunk pointer and remainder, reloads config
`timescale 1ns / 1ps
`default_nettype none
module size_class_free_list_allocator
  import scfl_pkg::*;
#(
  parameter int unsigned ARENA_BYTES = DEF_ARENA_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_item_t    in_item,
  output logic        busy,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW        = $clog2(ARENA_BYTES + 1);
  localparam int unsigned LW        = $clog2(ARENA_BYTES);
  localparam int unsigned NUM_SLOTS = ARENA_BYTES >> SLOT_SHIFT;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam logic [AW-1:0] OOM_LIMIT = AW'(ARENA_BYTES - CHUNK_BYTES);

  state_t state_r, state_nxt;
  in_item_t req_r, req_nxt;
  logic started_r, started_nxt;
  logic [FO_W-1:0] fo_r;
  logic [AW-1:0] hp_r, hp_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [AW-1:0] nxt_r, nxt_nxt;
  logic [LW-1:0] hdr_r, hdr_nxt;
  logic [CLS_W-1:0] cls_r, cls_nxt;
  logic [LW-1:0] heads_r [NUM_CLASSES];
  logic [LW-1:0] heads_nxt [NUM_CLASSES];
  out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  alu_op_t alu_op;
  logic [AW-1:0] alu_a, alu_b, alu_y;
  logic alu_co;

  mem_ctl_t mem_ctl;
  logic [SLOT_W-1:0] mem_rd_addr, mem_wr_addr;
  logic [LW-1:0] mem_wr_link, mem_rd_link;
  logic [CLS_W-1:0] mem_wr_cls, mem_rd_cls;

  logic [CLS_W-1:0] head_idx;
  logic [LW-1:0] head_q;

  logic is_free, is_null, is_bulk_free, is_bad, free_rej;
  logic size_zero, size_big, rem_big;
  logic [11:0] size_v;
  logic [REM_W-1:0] bytes;
  logic [FO_W-1:0] setup_off;
  logic [CLS_W-1:0] rc;
  logic [SLOT_W-1:0] free_slot;
  logic [LW-1:0] free_hdr;
  logic cfg_we;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [LW-1:0] h);
    return h[SLOT_SHIFT +: SLOT_W];
  endfunction

  function automatic logic [15:0] uaddr(input logic [LW-1:0] h);
    logic [31:0] t;
    t = 32'(h) | 32'(HDR_BYTES);
    return t[15:0];
  endfunction

  scfl_alu #(.W(AW)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .co (alu_co)
  );

  scfl_mem #(.DEPTH(NUM_SLOTS), .SLOT_W(SLOT_W), .LW(LW)) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_link (mem_wr_link),
    .wr_cls  (mem_wr_cls),
    .rd_link (mem_rd_link),
    .rd_cls  (mem_rd_cls)
  );

  assign is_free      = req_r.req_type == REQ_FREE;
  assign is_null      = req_r.free_addr == '0;
  assign is_bulk_free = req_r.free_addr >= 32'(ARENA_BYTES);
  assign is_bad       = (req_r.free_addr < 32'(MIN_BLOCK + HDR_BYTES)) ||
                        (req_r.free_addr[4:0] != 5'(HDR_BYTES));
  assign free_rej     = is_null || is_bulk_free || is_bad;
  assign free_slot    = req_r.free_addr[SLOT_SHIFT +: SLOT_W];
  assign free_hdr     = req_r.free_addr[LW-1:0] & ~LW'(HDR_BYTES);

  assign size_zero = req_r.req_size == '0;
  assign size_big  = req_r.req_size > 20'(MAX_SMALL);
  assign size_v    = req_r.req_size[11:0] + 12'(HDR_BYTES - 1);
  assign bytes     = REM_W'(MIN_BLOCK) << cls_r;
  assign rem_big   = |rem_r[REM_W-1:SLOT_SHIFT];
  assign rc        = rem_class(rem_r[11:0]);
  assign setup_off = (fo_r[FO_W-1:SLOT_SHIFT] == '0) ? FO_W'(MIN_BLOCK)
                                                     : {fo_r[FO_W-1:SLOT_SHIFT], 5'b0};

  always_comb begin
    case (state_r)
      ST_FREE_RD: head_idx = mem_rd_cls;
      ST_RETIRE:  head_idx = rc;
      default:    head_idx = cls_r;
    endcase
  end

  assign head_q = heads_r[head_idx];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (is_free) begin
          state_nxt = free_rej ? ST_IDLE : ST_FREE_RD;
        end else if (size_zero) begin
          state_nxt = ST_IDLE;
        end else if (!started_r) begin
          state_nxt = ST_SETUP;
        end else begin
          state_nxt = ST_SIZE;
        end
      end
      ST_FREE_RD:  state_nxt = ST_IDLE;
      ST_SETUP:    state_nxt = ST_SIZE;
      ST_SIZE:     state_nxt = size_big ? ST_IDLE : ST_CLASS;
      ST_CLASS: begin
        if (head_q != '0) begin
          state_nxt = ST_POP_RD;
        end else if (alu_co) begin
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_HEAP_HDR;
        end
      end
      ST_POP_RD:   state_nxt = ST_IDLE;
      ST_NEXT:     state_nxt = ST_OOM;
      ST_OOM: begin
        if (alu_co) begin
          state_nxt = ST_IDLE;
        end else if (rem_big) begin
          state_nxt = ST_RETIRE;
        end else begin
          state_nxt = ST_HEAP_HDR;
        end
      end
      ST_RETIRE:   state_nxt = ST_HEAP_HDR;
      ST_HEAP_HDR: state_nxt = ST_HEAP_REM;
      ST_HEAP_REM: state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    mem_ctl       = '0;
    mem_rd_addr   = '0;
    mem_wr_addr   = '0;
    mem_wr_link   = '0;
    mem_wr_cls    = '0;
    heads_nxt     = heads_r;
    started_nxt   = started_r;
    hp_nxt        = hp_r;
    rem_nxt       = rem_r;
    nxt_nxt       = nxt_r;
    hdr_nxt       = hdr_r;
    cls_nxt       = cls_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) req_nxt = in_item;
      end
      ST_DECODE: begin
        if (is_free) begin
          if (is_null) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out('0, '0, STAT_NULL_FREE);
          end else if (is_bulk_free) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out('0, CLS_BULK, STAT_BULK_FREE);
          end else if (is_bad) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out('0, '0, STAT_NULL_FREE);
          end else begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = free_slot;
            hdr_nxt       = free_hdr;
          end
        end else if (size_zero) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out('0, '0, STAT_ZERO);
        end
      end
      ST_FREE_RD: begin
        mem_ctl.link_we       = 1'b1;
        mem_ctl.cls_we        = 1'b1;
        mem_wr_addr           = slot_of(hdr_r);
        mem_wr_link           = head_q;
        mem_wr_cls            = mem_rd_cls;
        heads_nxt[mem_rd_cls] = hdr_r;
        out_valid_nxt         = 1'b1;
        out_nxt               = mk_out('0, {1'b0, mem_rd_cls}, STAT_FREED);
      end
      ST_SETUP: begin
        started_nxt = 1'b1;
        hp_nxt      = AW'(setup_off);
        alu_op      = ALU_SUB;
        alu_a       = AW'(CHUNK_BYTES);
        alu_b       = AW'(setup_off);
        rem_nxt     = alu_y[REM_W-1:0];
      end
      ST_SIZE: begin
        if (size_big) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out('0, CLS_BULK, STAT_BULK);
        end else begin
          cls_nxt = class_of(size_v);
        end
      end
      ST_CLASS: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(rem_r);
        alu_b  = AW'(bytes);
        if (head_q != '0) begin
          hdr_nxt       = head_q;
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = slot_of(head_q);
        end
      end
      ST_POP_RD: begin
        heads_nxt[cls_r] = mem_rd_link;
        mem_ctl.cls_we   = 1'b1;
        mem_wr_addr      = slot_of(hdr_r);
        mem_wr_cls       = cls_r;
        out_valid_nxt    = 1'b1;
        out_nxt          = mk_out(uaddr(hdr_r), {1'b0, cls_r}, STAT_LIST);
      end
      ST_NEXT: begin
        alu_op  = ALU_ADD;
        alu_a   = hp_r;
        alu_b   = AW'(rem_r);
        nxt_nxt = alu_y;
      end
      ST_OOM: begin
        alu_op = ALU_SUB;
        alu_a  = OOM_LIMIT;
        alu_b  = nxt_r;
        if (alu_co) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out('0, {1'b0, cls_r}, STAT_OOM);
        end else if (!rem_big) begin
          hp_nxt  = nxt_r;
          rem_nxt = REM_W'(CHUNK_BYTES);
        end
      end
      ST_RETIRE: begin
        mem_ctl.link_we = 1'b1;
        mem_ctl.cls_we  = 1'b1;
        mem_wr_addr     = slot_of(hp_r[LW-1:0]);
        mem_wr_link     = head_q;
        mem_wr_cls      = rc;
        heads_nxt[rc]   = hp_r[LW-1:0];
        hp_nxt          = nxt_r;
        rem_nxt         = REM_W'(CHUNK_BYTES);
      end
      ST_HEAP_HDR: begin
        mem_ctl.cls_we = 1'b1;
        mem_wr_addr    = slot_of(hp_r[LW-1:0]);
        mem_wr_cls     = cls_r;
        hdr_nxt        = hp_r[LW-1:0];
        alu_op         = ALU_ADD;
        alu_a          = hp_r;
        alu_b          = AW'(bytes);
        hp_nxt         = alu_y;
      end
      ST_HEAP_REM: begin
        alu_op        = ALU_SUB;
        alu_a         = AW'(rem_r);
        alu_b         = AW'(bytes);
        rem_nxt       = alu_y[REM_W-1:0];
        out_valid_nxt = 1'b1;
        out_nxt       = mk_out(uaddr(hdr_r), {1'b0, cls_r}, STAT_HEAP);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_FIRST_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      fo_r        <= FO_RESET;
      hp_r        <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      hp_r        <= hp_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      heads_r     <= heads_nxt;
      if (cfg_we) fo_r <= pwdata[FO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    nxt_r <= nxt_nxt;
    hdr_r <= hdr_nxt;
    cls_r <= cls_nxt;
    out_r <= out_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_FIRST_OFFSET) ? 32'(fo_r) : '0;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while an item is in progress");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_DECODE))
    else $error("accepted item did not enter decode");

  a_addr_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == STAT_LIST || out_item.status == STAT_HEAP))
      |-> (out_item.user_addr[4:0] == 5'(HDR_BYTES)))
    else $error("allocated address not header aligned");

  a_started: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("chunk setup flag dropped");

  a_rem_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HEAP_REM) |-> (rem_r >= bytes))
    else $error("heap cut larger than chunk remainder");

endmodule
`default_nettype wire

// ===== src/scfl_alu.sv =====
// shared add/subtract unit with carry or borrow out
`timescale 1ns / 1ps
`default_nettype none
module scfl_alu
  import scfl_pkg::*;
#(
  parameter int unsigned W = 17
) (
  input  alu_op_t        op,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   y,
  output logic           co
);

  logic [W:0] s;

  always_comb begin
    case (op)
      ALU_SUB: s = {1'b0, a} - {1'b0, b};
      default: s = {1'b0, a} + {1'b0, b};
    endcase
  end

  assign y  = s[W-1:0];
  assign co = s[W];

endmodule
`default_nettype wire

// ===== src/scfl_mem.sv =====
// per-slot link and header class memories with registered read
`timescale 1ns / 1ps
`default_nettype none
module scfl_mem
  import scfl_pkg::*;
#(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned SLOT_W = 11,
  parameter int unsigned LW     = 16
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [SLOT_W-1:0]  rd_addr,
  input  logic [SLOT_W-1:0]  wr_addr,
  input  logic [LW-1:0]      wr_link,
  input  logic [CLS_W-1:0]   wr_cls,
  output logic [LW-1:0]      rd_link,
  output logic [CLS_W-1:0]   rd_cls
);

  logic [LW-1:0]    link_mem [DEPTH];
  logic [CLS_W-1:0] cls_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (ctl.cls_we) begin
      cls_mem[wr_addr] <= wr_cls;
    end
    if (ctl.rd_en) begin
      rd_link <= link_mem[rd_addr];
      rd_cls  <= cls_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_size_class_free_list_allocator.sv =====
// testbench for the size-class free-list allocator: directed and random requests against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_size_class_free_list_allocator;
  import scfl_pkg::*;

  localparam int unsigned ARENA      = DEF_ARENA_BYTES;
  localparam int unsigned NUM_SLOTS  = ARENA >> SLOT_SHIFT;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned DRAIN_WAIT = 20;

  logic        clk;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  in_item_t    in_item = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  size_class_free_list_allocator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // allocator shadow state
  logic [FO_W-1:0]  first_offset_q = FO_RESET;
  logic             arena_open     = 1'b0;
  logic [15:0]      avail_head [NUM_CLASSES];
  logic [15:0]      link_mem   [NUM_SLOTS];
  logic [CLS_W-1:0] class_mem  [NUM_SLOTS];
  logic [16:0]      chunk_ptr  = '0;
  logic [REM_W-1:0] chunk_left = '0;

  out_item_t   pending_results[$];
  logic [15:0] live_addrs[$];
  int unsigned known_slots[$];
  bit          slot_known [NUM_SLOTS];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  initial begin
    for (int i = 0; i < NUM_CLASSES; i++) avail_head[i] = '0;
  end

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s at %0t: got %0d want %0d", field, $realtime, got, want);
    error_count++;
  endtask

  task automatic mark_slot(input logic [10:0] slot);
    if (!slot_known[slot]) begin
      slot_known[slot] = 1'b1;
      known_slots.push_back(32'(slot));
    end
  endtask

  task automatic push_block(input logic [15:0] hdr, input logic [CLS_W-1:0] cls);
    link_mem[hdr[15:5]]  = avail_head[cls];
    class_mem[hdr[15:5]] = cls;
    mark_slot(hdr[15:5]);
    avail_head[cls] = hdr;
  endtask

  // works out the result of one accepted item and updates the shadow state
  task automatic predict_result(input in_item_t it);
    out_item_t        r;
    logic [15:0]      hdr;
    logic [CLS_W-1:0] cls;
    logic [CLS_W-1:0] rcls;
    int unsigned      bytes;
    int unsigned      off;
    r = '0;
    if (it.req_type == REQ_FREE) begin
      if (it.free_addr == 32'd0) begin
        r.status = STAT_NULL_FREE;
      end else if (it.free_addr >= ARENA) begin
        r.size_class = CLS_BULK;
        r.status     = STAT_BULK_FREE;
      end else if (it.free_addr < MIN_BLOCK + HDR_BYTES || it.free_addr[4:0] != 5'd8) begin
        r.status = STAT_NULL_FREE;
      end else begin
        hdr = 16'(it.free_addr - HDR_BYTES);
        cls = class_mem[hdr[15:5]];
        push_block(hdr, cls);
        r.size_class = 4'(cls);
        r.status     = STAT_FREED;
      end
    end else if (it.req_size == '0) begin
      r.status = STAT_ZERO;
    end else begin
      if (!arena_open) begin
        off = 32'(first_offset_q & 12'hFE0);
        if (off < MIN_BLOCK) off = MIN_BLOCK;
        arena_open = 1'b1;
        chunk_ptr  = 17'(off);
        chunk_left = REM_W'(CHUNK_BYTES - off);
      end
      if (it.req_size > MAX_SMALL) begin
        r.size_class = CLS_BULK;
        r.status     = STAT_BULK;
      end else begin
        cls = '0;
        while (cls < 7 && (MIN_BLOCK << cls) < it.req_size + HDR_BYTES) cls++;
        bytes = MIN_BLOCK << cls;
        r.size_class = 4'(cls);
        if (avail_head[cls] != '0) begin
          hdr = avail_head[cls];
          avail_head[cls] = link_mem[hdr[15:5]];
          class_mem[hdr[15:5]] = cls;
          r.user_addr = hdr + 16'(HDR_BYTES);
          r.status    = STAT_LIST;
          live_addrs.push_back(r.user_addr);
        end else if (chunk_left < bytes && chunk_ptr + chunk_left + CHUNK_BYTES > ARENA) begin
          r.status = STAT_OOM;
        end else begin
          if (chunk_left < bytes) begin
            if (chunk_left >= MIN_BLOCK) begin
              rcls = '0;
              while (rcls < 7 && (MIN_BLOCK << (rcls + 1)) <= chunk_left) rcls++;
              push_block(chunk_ptr[15:0], rcls);
            end
            chunk_ptr  = chunk_ptr + chunk_left;
            chunk_left = REM_W'(CHUNK_BYTES);
          end
          hdr = chunk_ptr[15:0];
          class_mem[hdr[15:5]] = cls;
          mark_slot(hdr[15:5]);
          chunk_ptr  = chunk_ptr + 17'(bytes);
          chunk_left = chunk_left - REM_W'(bytes);
          r.user_addr = hdr + 16'(HDR_BYTES);
          r.status    = STAT_HEAP;
          live_addrs.push_back(r.user_addr);
        end
      end
    end
    pending_results.push_back(r);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no pending item", 32'(out_item), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.user_addr !== want.user_addr)
          report_mismatch("user_addr", 32'(out_item.user_addr), 32'(want.user_addr));
        if (out_item.size_class !== want.size_class)
          report_mismatch("size_class", 32'(out_item.size_class), 32'(want.size_class));
        if (out_item.status !== want.status)
          report_mismatch("status field", 32'(out_item.status), 32'(want.status));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (psel && penable && pwrite && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // drives one item, waits for it to be taken, then for a nonzero gap drops start and idles
  task automatic send_item(input in_item_t it, input int unsigned gap);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict_result(it);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [FO_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'({REG_FIRST_OFFSET, 2'b00});
    pwdata  <= {20'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    first_offset_q = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t alloc_item(input logic [19:0] size);
    in_item_t it;
    it.req_type  = REQ_ALLOC;
    it.req_size  = size;
    it.free_addr = $urandom;
    return it;
  endfunction

  function automatic in_item_t free_item(input logic [31:0] addr);
    in_item_t it;
    it.req_type  = REQ_FREE;
    it.req_size  = 20'($urandom);
    it.free_addr = addr;
    return it;
  endfunction

  function automatic logic [31:0] junk_addr();
    logic [31:0] a;
    a = $urandom_range(0, ARENA - 1);
    if (a[4:0] == 5'd8) a[0] = 1'b1;
    return a;
  endfunction

  task automatic make_item(input int unsigned alloc_pct, output in_item_t it);
    int unsigned sel;
    int unsigned cls;
    int unsigned lo;
    int unsigned hi;
    int unsigned idx;
    logic [31:0] a;
    if ($urandom_range(0, 99) < alloc_pct) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        it = alloc_item('0);
      end else if (sel < 8) begin
        it = alloc_item(20'($urandom_range(MAX_SMALL + 1, 20'hFFFFF)));
      end else begin
        cls = $urandom_range(0, 7);
        lo  = (cls == 0) ? 1 : (16 << cls) - 7;
        hi  = (32 << cls) - 8;
        case ($urandom_range(0, 5))
          0: it = alloc_item(20'(lo));
          1: it = alloc_item(20'(hi));
          default: it = alloc_item(20'($urandom_range(lo, hi)));
        endcase
      end
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 70 && live_addrs.size() != 0) begin
        idx = $urandom_range(0, live_addrs.size() - 1);
        it  = free_item({16'd0, live_addrs[idx]});
        live_addrs.delete(idx);
      end else if (sel < 80 && known_slots.size() != 0) begin
        idx = $urandom_range(0, known_slots.size() - 1);
        it  = free_item(32'(known_slots[idx] * MIN_BLOCK + HDR_BYTES));
      end else if (sel < 87) begin
        it = free_item('0);
      end else if (sel < 94) begin
        a = $urandom;
        if (a < ARENA) a = a | (32'd1 << $urandom_range(16, 31));
        it = free_item(a);
      end else begin
        it = free_item(junk_addr());
      end
    end
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned alloc_pct,
                              input bit with_gaps);
    in_item_t it;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2 && $urandom_range(0, 1) == 1) wait_quiet();
      make_item(alloc_pct, it);
      send_item(it, with_gaps ? pick_gap() : 0);
    end
    wait_quiet();
  endtask

  task automatic test_first_offset();
    cfg_write(12'd0);
    cfg_write(12'hFFF);
    case ($urandom_range(0, 3))
      0: cfg_write(12'($urandom_range(0, 31)));
      1: cfg_write(12'd4064);
      2: cfg_write(12'hFFF);
      default: cfg_write(12'($urandom_range(32, 4095)));
    endcase
  endtask

  task automatic test_directed();
    logic [15:0] a;
    send_item(alloc_item('0), pick_gap());
    send_item(alloc_item(20'd1), pick_gap());
    send_item(alloc_item(20'd24), pick_gap());
    send_item(alloc_item(20'd25), pick_gap());
    send_item(alloc_item(20'(MAX_SMALL)), pick_gap());
    send_item(alloc_item(20'(MAX_SMALL + 1)), pick_gap());
    send_item(alloc_item(20'hFFFFF), pick_gap());
    send_item(free_item('0), pick_gap());
    send_item(free_item(32'hFFFF_FFFF), pick_gap());
    send_item(free_item(32'(ARENA)), pick_gap());
    send_item(free_item(32'd8), pick_gap());
    send_item(free_item(32'd39), pick_gap());
    send_item(free_item(32'(ARENA - 1)), pick_gap());
    a = live_addrs.pop_front();
    send_item(free_item({16'd0, a}), pick_gap());
    send_item(alloc_item(20'd1), pick_gap());
    // double free, then both copies come back from the list
    send_item(free_item({16'd0, a}), pick_gap());
    send_item(free_item({16'd0, a}), pick_gap());
    send_item(alloc_item(20'd20), pick_gap());
    send_item(alloc_item(20'd2), pick_gap());
    send_item(alloc_item(20'd2000), pick_gap());
    send_item(alloc_item(20'd4000), pick_gap());
    send_item(alloc_item(20'd100), pick_gap());
    wait_quiet();
  endtask

  task automatic test_fill_arena();
    cfg_write(12'd4064);
    random_phase(300, 75, 1'b1);
  endtask

  task automatic test_drain_arena();
    cfg_write(12'd32);
    random_phase(250, 25, 1'b1);
  endtask

  task automatic test_back_to_back();
    cfg_write(12'($urandom));
    random_phase(200, 50, 1'b0);
  endtask

  task automatic test_mixed();
    cfg_write(12'($urandom_range(32, 4064)));
    random_phase(350, 60, 1'b1);
  endtask

  initial begin : main
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_offset();
    test_directed();
    test_fill_arena();
    test_drain_arena();
    test_back_to_back();
    test_mixed();
    wait_quiet();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never seen", 0, 32'(pending_results.size()));
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
